FILE: rtl/thinning_subiteration_pass_core_defines.svh
// assertion helpers for the checker file
`ifndef THINNING_SUBITERATION_PASS_CORE_DEFINES_SVH
`define THINNING_SUBITERATION_PASS_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define THIN_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define THIN_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/thin_pkg.sv
package thin_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_SUB_ITERATION = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] MIN_IMAGE_SIZE     = 11'd3;

  // one window column: bit 0 top row, bit 1 middle row, bit 2 bottom row
  typedef logic [2:0] win_col_t;

  // 3x3 window, c2 is the newest column
  typedef struct packed {
    win_col_t c2;
    win_col_t c1;
    win_col_t c0;
  } win_t;

endpackage

FILE: rtl/thin_ram.sv
module thin_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

FILE: rtl/thin_win_cell.sv
module thin_win_cell import thin_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     shift_en,
  input  win_col_t col_in,
  output win_col_t col_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

endmodule

FILE: rtl/thin_decide.sv
module thin_decide import thin_pkg::*; (
  input  win_t win,
  input  logic sub_iteration,
  output logic del
);

  logic [7:0] ring;
  logic [3:0] whites;
  logic [3:0] steps;
  logic       centre;
  logic       t1;
  logic       t2;

  // ring order P2..P9, clockwise from the pixel above the centre
  assign ring[0] = win.c1[0];
  assign ring[1] = win.c2[0];
  assign ring[2] = win.c2[1];
  assign ring[3] = win.c2[2];
  assign ring[4] = win.c1[2];
  assign ring[5] = win.c0[2];
  assign ring[6] = win.c0[1];
  assign ring[7] = win.c0[0];
  assign centre  = win.c1[1];

  assign whites = 4'($countones(ring));

  always_comb begin
    steps = '0;
    for (int i = 0; i < 8; i++) begin
      steps = steps + 4'(!ring[i] && ring[(i + 1) & 7]);
    end
  end

  always_comb begin
    if (sub_iteration) begin
      t1 = !ring[0] || !ring[2] || !ring[6];
      t2 = !ring[0] || !ring[4] || !ring[6];
    end else begin
      t1 = !ring[0] || !ring[2] || !ring[4];
      t2 = !ring[2] || !ring[4] || !ring[6];
    end
  end

  assign del = centre && (steps == 4'd1) && (whites >= 4'd2) && (whites <= 4'd6) && t1 && t2;

endmodule

FILE: rtl/thinning_subiteration_pass_core.sv
// one sub-iteration of two-pass thinning over a binary frame in raster order
//
// input channel: one pixel per item (1 white), in_drain marks a filler item
// that advances the stream as a black pixel. after each frame the host sends
// image_width+1 drain items so the window empties.
// result channel: the first image_width+1 items of a frame give no result;
// after that each item gives the pixel one row and one pixel behind it.
// the last result carries out_frame_last and out_any_deleted.
// configuration: write image_width, image_height, sub_iteration while idle.
//
// one item per cycle while the receiver takes results; a result is registered
// in the cycle after its item. the window is the incoming column and a chain
// of two column cells, fed by a two-bit wide line store of MAX_WIDTH entries
// (one read and one write per cycle).
// reset clears counters, window and flags; the line store is not cleared,
// row zero of every frame overwrites it before use.
// when the receiver stalls with a result pending, in_ready drops until the
// result is taken.
module thinning_subiteration_pass_core import thin_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pixel_in,
  input  logic                  in_drain,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pixel_out,
  output logic                  out_frame_last,
  output logic                  out_any_deleted,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 3);
  localparam int CMPW_W = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CMPW_H = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [CMPW_W-1:0] x;
    x = CMPW_W'(v);
    if (x < CMPW_W'(MIN_IMAGE_SIZE)) x = CMPW_W'(MIN_IMAGE_SIZE);
    else if (x > CMPW_W'(MAX_WIDTH)) x = CMPW_W'(MAX_WIDTH);
    return WW'(x);
  endfunction

  function automatic logic [RW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [CMPW_H-1:0] x;
    x = CMPW_H'(v);
    if (x < CMPW_H'(MIN_IMAGE_SIZE)) x = CMPW_H'(MIN_IMAGE_SIZE);
    else if (x > CMPW_H'(MAX_HEIGHT)) x = CMPW_H'(MAX_HEIGHT);
    return RW'(x);
  endfunction

  // configuration registers
  logic [CFG_DATA_W-1:0] width_r, width_nxt;
  logic [CFG_DATA_W-1:0] height_r, height_nxt;
  logic                  sub_r, sub_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    sub_nxt    = sub_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_nxt  = cfg_wr_data;
        REG_IMAGE_HEIGHT:  height_nxt = cfg_wr_data;
        REG_SUB_ITERATION: sub_nxt    = cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_IMAGE_WIDTH;
      height_r <= RESET_IMAGE_HEIGHT;
      sub_r    <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      sub_r    <= sub_nxt;
    end
  end

  logic [WW-1:0] wdt, wdt_nxt;
  logic [RW-1:0] hgt;

  assign wdt     = clamp_w(width_r);
  assign wdt_nxt = clamp_w(width_nxt);
  assign hgt     = clamp_h(height_r);

  // position of the incoming item
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          flag_r, flag_nxt;
  logic          wrap_now;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [CW:0]   col_inc;

  logic accept;
  logic v;
  logic emit;
  logic last;
  logic test_ok;
  logic del;
  logic decide_del;
  logic pix;

  // output register
  logic out_valid_r, out_pix_r, out_last_r, out_anydel_r;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign v        = in_pixel_in & ~in_drain;

  // a column left at or above a narrowed width moves on to the next row
  assign wrap_now = (CW + 1)'(col_r) >= (CW + 1)'(wdt);
  assign c        = wrap_now ? '0 : col_r;
  assign r        = wrap_now ? row_r + RW'(1) : row_r;
  assign col_inc  = (CW + 1)'(c) + (CW + 1)'(1);

  assign emit    = (r >= RW'(2)) || ((r == RW'(1)) && (c >= CW'(1)));
  assign last    = r >= (hgt + RW'(1));
  assign test_ok = (c >= CW'(2)) && (r >= RW'(2)) && (r < hgt);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    flag_nxt = flag_r;
    if (accept) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        flag_nxt = 1'b0;
      end else begin
        flag_nxt = flag_r | del;
        if (col_inc >= (CW + 1)'(wdt)) begin
          col_nxt = '0;
          row_nxt = r + RW'(1);
        end else begin
          col_nxt = col_inc[CW-1:0];
          row_nxt = r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      flag_r <= flag_nxt;
    end
  end

  // line store: bit 1 two rows up, bit 0 one row up
  logic [CW-1:0] rd_addr;
  logic [1:0]    ram_rd;
  logic [1:0]    lines;
  logic [1:0]    wr_data;
  logic          byp_v_r, byp_v_nxt;
  logic [1:0]    byp_d_r;

  // read ahead for the column of the next item
  always_comb begin
    if (!rst_n) begin
      rd_addr = '0;
    end else if ((CW + 1)'(col_nxt) >= (CW + 1)'(wdt_nxt)) begin
      rd_addr = '0;
    end else begin
      rd_addr = col_nxt;
    end
  end

  assign lines     = byp_v_r ? byp_d_r : ram_rd;
  assign wr_data   = {lines[0], v};
  assign byp_v_nxt = accept && (rd_addr == c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else begin
      byp_v_r <= byp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= wr_data;
  end

  thin_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (c),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (ram_rd)
  );

  // window: incoming column plus a chain of column cells, cell 1 takes the new column
  win_col_t cell_q [2];
  win_col_t new_col;
  win_t     win_new;

  assign new_col = {v, lines[0], lines[1]};

  for (genvar j = 0; j < 2; j++) begin : g_cell
    win_col_t cell_d;
    if (j == 1) begin : g_head
      assign cell_d = new_col;
    end else begin : g_link
      assign cell_d = cell_q[j+1];
    end
    thin_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .col_in   (cell_d),
      .col_r    (cell_q[j])
    );
  end

  assign win_new = '{c2: new_col, c1: cell_q[1], c0: cell_q[0]};

  thin_decide u_decide (
    .win           (win_new),
    .sub_iteration (sub_r),
    .del           (decide_del)
  );

  assign del = test_ok && decide_del;
  // center of the shifted window, also the last pixel of a row at column zero
  assign pix = cell_q[1][1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && (emit || last)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (emit || last)) begin
      out_pix_r    <= pix & ~del;
      out_last_r   <= last;
      out_anydel_r <= last & flag_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_frame_last  = out_last_r;
  assign out_any_deleted = out_anydel_r;

endmodule

FILE: rtl/thin_checker.sv
`include "thinning_subiteration_pass_core_defines.svh"

module thin_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_pixel_out,
  input logic out_frame_last,
  input logic out_any_deleted
);

  `THIN_CHK_NEXT(a_out_hold, out_valid && !out_ready,
                 out_valid && $stable({out_pixel_out, out_frame_last, out_any_deleted}),
                 "result changed while stalled")

  // the deletion summary only rides on the last pixel of a frame
  `THIN_CHK_NOW(a_del_only_last, out_valid && !out_frame_last, !out_any_deleted,
                "any_deleted off the frame end")

  // input only waits on a pending result
  `THIN_CHK_NOW(a_ready_when_empty, !out_valid, in_ready,
                "input stalled with no result pending")

  `THIN_CHK_NOW(a_result_needs_item, $rose(out_valid), $past(in_valid && in_ready),
                "result without an accepted item")

endmodule

bind thinning_subiteration_pass_core thin_checker u_thin_checker (.*);
